[sv/b64_pkg.sv]
`default_nettype none
package b64_pkg;

  // Number of pending groups the queue between front and back can hold.
  localparam int unsigned QDEPTH = 2;

  localparam logic [6:0] PAD_CHAR = 7'd61;

  // One group of up to three bytes, ready to be turned into four characters.
  typedef struct packed {
    logic [23:0] bits;   // first byte in the top eight bits
    logic [1:0]  pad;    // number of trailing '=' characters (0 to 2)
    logic        last;   // group closes the message
  } grp_t;

  // Standard alphabet lookup of one 6-bit slice.
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (v < 6'd26) begin
      return w + 7'd65;
    end else if (v < 6'd52) begin
      return w + 7'd71;
    end else if (v < 6'd62) begin
      return w - 7'd4;
    end else if (v == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage
`default_nettype wire

[sv/base64_stream_encoder.sv]
// Path: with the back part idle, a group closed by an accepted byte is written into the queue,
// loaded into the back's group register, and its first character registered as out_valid rises.
// Throughput: four characters per group at one character per cycle on the output side while
// out_ready is high, so sustained input is set by the single character serializer.
// A byte that only fills the hold registers is taken every cycle while the queue has room.
// Reset (rst_n, synchronous, active low) empties the hold count, the queue and the output.
`default_nettype none
module base64_stream_encoder (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [7:0]  in_data_byte,
  input  wire        in_is_last,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [6:0] out_char,
  output logic       out_end_of_text
);
  import b64_pkg::*;

  // The front collects bytes into groups of three and classifies the
  // closing byte. Each finished group is a single queue transaction.
  logic  in_accept;
  logic  push;
  grp_t  push_grp;
  logic  not_full;
  logic  q_valid;
  logic  pop;
  grp_t  q_grp;

  // Input is taken whenever the queue has room, so a closing byte can
  // always be written. Bytes that are only held are refused too while the queue is full.
  assign in_ready  = not_full;
  assign in_accept = in_valid && in_ready;

  b64_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_accept    (in_accept),
    .in_data_byte (in_data_byte),
    .in_is_last   (in_is_last),
    .push         (push),
    .push_grp     (push_grp)
  );

  // Two groups of slack let the front keep accepting while the back
  // serializes or while the output side stalls.
  b64_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .not_full (not_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .q_grp    (q_grp)
  );

  // The back emits the four characters of a group one per cycle while out_ready is high,
  // through a registered output; the next group is loaded as the fourth enters it.
  b64_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_grp           (q_grp),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_end_of_text (out_end_of_text)
  );

endmodule
`default_nettype wire

[sv/b64_front.sv]
`default_nettype none
module b64_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_accept,
  input  wire [7:0]        in_data_byte,
  input  wire              in_is_last,
  output logic             push,
  output b64_pkg::grp_t    push_grp
);
  import b64_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] held_r [2];

  // A group is released by the third byte of a group or by the last byte.
  assign push = in_accept && (cnt_r[1] || in_is_last);

  always_comb begin
    push_grp = '0;
    cnt_nxt  = cnt_r;
    if (cnt_r[1]) begin
      push_grp.bits = {held_r[0], held_r[1], in_data_byte};
      push_grp.pad  = 2'd0;
      push_grp.last = in_is_last;
    end else if (cnt_r[0]) begin
      push_grp.bits = {held_r[0], in_data_byte, 8'd0};
      push_grp.pad  = 2'd1;
      push_grp.last = 1'b1;
    end else begin
      push_grp.bits = {in_data_byte, 16'd0};
      push_grp.pad  = 2'd2;
      push_grp.last = 1'b1;
    end
    if (in_accept) begin
      if (cnt_r[1] || in_is_last) begin
        cnt_nxt = 2'd0;
      end else begin
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && !cnt_r[1] && !in_is_last) begin
      held_r[cnt_r[0]] <= in_data_byte;
    end
  end

  // in_valid is only used by the checks below.
`ifndef ASSERT_OFF
  a_accept_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> in_valid) else $error("front accepted without valid");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("hold count out of range");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_is_last) |=> cnt_r == 2'd0) else $error("last byte left bytes held");
`endif

endmodule
`default_nettype wire

[sv/b64_queue.sv]
`default_nettype none
module b64_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  b64_pkg::grp_t    push_grp,
  output logic             not_full,
  output logic             q_valid,
  input  wire              pop,
  output b64_pkg::grp_t    q_grp
);
  import b64_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  grp_t            mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r, count_nxt;
  logic            do_pop;

  assign not_full = count_r != (PW+1)'(QDEPTH);
  assign q_valid  = count_r != '0;
  assign q_grp    = mem_r[rd_ptr_r];
  assign do_pop   = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full) else $error("queue written while full");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(QDEPTH)) else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a write");
`endif

endmodule
`default_nettype wire

[sv/b64_back.sv]
`default_nettype none
module b64_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  input  b64_pkg::grp_t    q_grp,
  output logic             pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [6:0]       out_char,
  output logic             out_end_of_text
);
  import b64_pkg::*;

  grp_t       cur_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       ov_r;
  logic [6:0] char_r;
  logic       eot_r;
  logic       adv;
  logic [5:0] slice;
  logic [6:0] char_nxt;

  // While a group is loaded, a character moves into the output register whenever it is empty or drained.
  assign adv = busy_r && (!ov_r || out_ready);
  assign pop = !busy_r || (adv && idx_r == 2'd3);

  always_comb begin
    unique case (idx_r)
      2'd0: slice = cur_r.bits[23:18];
      2'd1: slice = cur_r.bits[17:12];
      2'd2: slice = cur_r.bits[11:6];
      2'd3: slice = cur_r.bits[5:0];
      default: slice = cur_r.bits[5:0];
    endcase
    if ({1'b0, idx_r} < 3'd4 - {1'b0, cur_r.pad}) begin
      char_nxt = b64_char(slice);
    end else begin
      char_nxt = PAD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      if (pop && q_valid) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (adv) begin
        if (idx_r == 2'd3) begin
          busy_r <= 1'b0;
        end
        idx_r <= idx_r + 2'd1;
      end
      if (adv) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_valid) begin
      cur_r <= q_grp;
    end
    if (adv) begin
      char_r <= char_nxt;
      eot_r  <= (idx_r == 2'd3) && cur_r.last;
    end
  end

  assign out_valid       = ov_r;
  assign out_char        = char_r;
  assign out_end_of_text = eot_r;

`ifndef ASSERT_OFF
  a_idx_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && idx_r != 2'd0) |-> $past(busy_r)) else $error("index moved while idle");
  a_last_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && idx_r == 2'd3 && cur_r.pad != 2'd0) |=> out_char == PAD_CHAR)
    else $error("partial group did not end in padding");
  a_double_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && idx_r == 2'd2 && cur_r.pad == 2'd2) |=> out_char == PAD_CHAR)
    else $error("one-byte group missing first pad");
`endif

endmodule
`default_nettype wire
